FILE: rtl/core/lrf_pkg.sv
// ----------------------------------------------------------------------------
// lrf_pkg
// Types and constants shared by the line-assembling receive FIFO modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lrf_pkg;

   localparam logic [7:0] CR_BYTE = 8'd13;
   localparam logic [7:0] LF_BYTE = 8'd10;

   typedef enum logic [1:0] {
      OP_PUSH       = 2'd0,
      OP_TAKE       = 2'd1,
      OP_READ_LINE  = 2'd2,
      OP_LINE_EVENT = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_STORED   = 3'd0,
      ST_FILTERED = 3'd1,
      ST_OVERFLOW = 3'd2,
      ST_BYTE     = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_LINE     = 3'd5,
      ST_FLUSHED  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE       = 2'd0,
      S_TAKE_WAIT  = 2'd1,
      S_LINE_ISSUE = 2'd2,
      S_LINE_DATA  = 2'd3
   } state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      status_type status;
      logic [7:0] pending_lines;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: rtl/core/lrf_ram.sv
// ----------------------------------------------------------------------------
// lrf_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lrf_out.sv
// ----------------------------------------------------------------------------
// lrf_out
// Output register that holds one result transaction until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lrf_out (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire lrf_pkg::rsp_item_type item,
   output logic                       can_load,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output lrf_pkg::rsp_item_type      rsp_item
);

   import lrf_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lrf_ctrl.sv
// ----------------------------------------------------------------------------
// lrf_ctrl
// Ring pointers, line count and the sequencer that drives the byte RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module lrf_ctrl #(
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic                     csr_wr_data,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_op,
   input  wire logic [7:0]               req_data_byte,
   input  wire logic                     can_load,
   output logic                          load,
   output lrf_pkg::rsp_item_type         item,
   output logic                          wr_en,
   output logic      [$clog2(DEPTH)-1:0] wr_addr,
   output logic      [7:0]               wr_data,
   output logic                          rd_en,
   output logic      [$clog2(DEPTH)-1:0] rd_addr,
   input  wire logic [7:0]               rd_data
);

   import lrf_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   state_type     state_ff;
   state_type     state_in;
   logic [AW-1:0] head_ff;
   logic [AW-1:0] head_in;
   logic [AW-1:0] tail_ff;
   logic [AW-1:0] tail_in;
   logic [7:0]    line_count_ff;
   logic [7:0]    line_count_in;
   logic          consumer_ff;

   op_type        op;
   logic [AW-1:0] head_nx;
   logic [AW-1:0] tail_nx;
   logic          empty;
   logic          full;
   logic          accept;
   logic          no_line;
   logic          line_start;
   logic          line_end;

   assign op      = op_type'(req_op);
   assign head_nx = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
   assign tail_nx = (tail_ff == LAST_SLOT) ? '0 : tail_ff + AW'(1);
   assign empty   = (head_ff == tail_ff);
   assign full    = (head_nx == tail_ff);
   assign no_line = (line_count_ff == 8'd0);

   assign req_stall = !((state_ff == S_IDLE) && can_load);
   assign accept    = req_valid && !req_stall;

   assign line_start = !no_line &&
                       ((op == OP_READ_LINE) || ((op == OP_LINE_EVENT) && consumer_ff));
   assign line_end   = (rd_data == 8'd0) || (rd_data == CR_BYTE) || rd_data[7];

   assign wr_addr = head_nx;
   assign wr_data = req_data_byte;
   assign rd_addr = tail_nx;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if ((op == OP_TAKE) && !empty) begin
                  state_in = S_TAKE_WAIT;
               end else if (line_start) begin
                  state_in = S_LINE_ISSUE;
               end
            end
         end
         S_TAKE_WAIT: begin
            if (can_load) begin
               state_in = S_IDLE;
            end
         end
         S_LINE_ISSUE: begin
            if (!empty) begin
               state_in = S_LINE_DATA;
            end else if (can_load) begin
               state_in = S_IDLE;
            end
         end
         S_LINE_DATA: begin
            if (can_load) begin
               state_in = line_end ? S_IDLE : S_LINE_ISSUE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath updates and result generation.
   always_comb begin
      load          = 1'b0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      head_in       = head_ff;
      tail_in       = tail_ff;
      line_count_in = line_count_ff;
      item.out_byte = 8'd0;
      item.last     = 1'b1;
      item.status   = ST_EMPTY;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_PUSH: begin
                     load = 1'b1;
                     if (full) begin
                        head_in     = tail_ff;
                        item.status = ST_OVERFLOW;
                     end else if ((req_data_byte == 8'd0) || (req_data_byte == LF_BYTE)) begin
                        item.status = ST_FILTERED;
                     end else begin
                        wr_en       = 1'b1;
                        head_in     = head_nx;
                        item.status = ST_STORED;
                        if (req_data_byte == CR_BYTE) begin
                           line_count_in = line_count_ff + 8'd1;
                        end
                     end
                  end
                  OP_TAKE: begin
                     if (empty) begin
                        load = 1'b1;
                     end else begin
                        rd_en   = 1'b1;
                        tail_in = tail_nx;
                     end
                  end
                  OP_READ_LINE: begin
                     if (no_line) begin
                        load = 1'b1;
                     end else begin
                        line_count_in = line_count_ff - 8'd1;
                     end
                  end
                  OP_LINE_EVENT: begin
                     if (no_line) begin
                        load = 1'b1;
                     end else if (consumer_ff) begin
                        line_count_in = line_count_ff - 8'd1;
                     end else begin
                        load        = 1'b1;
                        head_in     = tail_ff;
                        item.status = ST_FLUSHED;
                     end
                  end
                  default: load = 1'b0;
               endcase
            end
         end
         S_TAKE_WAIT: begin
            load          = can_load;
            item.out_byte = rd_data;
            item.status   = ST_BYTE;
         end
         S_LINE_ISSUE: begin
            item.status = ST_LINE;
            if (empty) begin
               load = can_load;
            end else begin
               rd_en   = 1'b1;
               tail_in = tail_nx;
            end
         end
         S_LINE_DATA: begin
            load        = can_load;
            item.status = ST_LINE;
            if (!line_end) begin
               item.out_byte = rd_data;
               item.last     = 1'b0;
            end
         end
         default: load = 1'b0;
      endcase
      item.pending_lines = line_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         line_count_ff <= 8'd0;
         consumer_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         line_count_ff <= line_count_in;
         if (csr_wr_en) begin
            consumer_ff <= csr_wr_data;
         end
      end
   end

`ifndef ASSERT_OFF
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("RAM written and read in the same cycle");

   a_take_data_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAKE_WAIT) && $past(state_ff == S_TAKE_WAIT) |-> $stable(rd_data))
      else $error("Read data changed while a taken byte waits");

   a_count_busy_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> $stable(line_count_ff))
      else $error("Line count changed during a multi-cycle transaction");

   a_load_room: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("Result loaded while the output register is held");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/line_assembling_rx_fifo.sv
// ----------------------------------------------------------------------------
// line_assembling_rx_fifo
// Receive byte ring with a count of pending CR-terminated lines.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    req_op, req_data_byte
// rsp      out        rsp_valid/stall    rsp_out_byte, rsp_last, rsp_status,
//                                        rsp_pending_lines
// csr      in         csr_wr_en          csr_wr_data
//
// Push, flush and status-only transactions load their result from S_IDLE; a take
// reads the byte RAM and loads the byte in S_TAKE_WAIT. A line read reads each
// character in S_LINE_ISSUE and loads it in S_LINE_DATA; an ending byte, or an
// empty ring at S_LINE_ISSUE, loads the terminator. RAM reads are registered.
// Reset clears the pointers, the line count and the register; the RAM is
// not cleared and the block is ready in the cycle after reset.
// A stalled result holds the output register and, with it, further input.
`default_nettype none

module line_assembling_rx_fifo #(
   parameter int DEPTH = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_op,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_out_byte,
   output logic            rsp_last,
   output logic      [2:0] rsp_status,
   output logic      [7:0] rsp_pending_lines
);

   import lrf_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic          can_load;
   logic          load;
   rsp_item_type  item;
   rsp_item_type  rsp_item;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   lrf_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   lrf_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_data_byte(req_data_byte),
      .can_load     (can_load),
      .load         (load),
      .item         (item),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   lrf_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .item     (item),
      .can_load (can_load),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   assign rsp_out_byte      = rsp_item.out_byte;
   assign rsp_last          = rsp_item.last;
   assign rsp_status        = rsp_item.status;
   assign rsp_pending_lines = rsp_item.pending_lines;

endmodule

`default_nettype wire
